FILE: rtl/sks_pkg.sv
// shared types and constants for the stable ascending key sorter
package sks_pkg;

   localparam int CAPACITY = 32;
   localparam int KEY_W    = 16;
   localparam int TAG_W    = 8;

   typedef struct packed {
      logic [KEY_W-1:0] sort_key;
      logic [TAG_W-1:0] payload_tag;
      logic             final_record;
   } sks_req_type;

   typedef struct packed {
      logic [KEY_W-1:0] sorted_key;
      logic [TAG_W-1:0] sorted_tag;
      logic             end_of_run;
      logic             dropped_records;
   } sks_rsp_type;

   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } sks_rec_type;

   typedef struct packed {
      logic insert;
      logic drain;
   } sks_ctl_type;

endpackage

FILE: rtl/sks_cell.sv
// one storage cell of the sorting chain
module sks_cell import sks_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  sks_ctl_type      ctl,
   input  logic [KEY_W-1:0] new_key,
   input  logic [TAG_W-1:0] new_tag,
   input  sks_rec_type      prev_rec,
   input  logic             prev_gt,
   input  sks_rec_type      next_rec,
   output sks_rec_type      rec,
   output logic             gt
);

   logic             valid_ff, valid_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [TAG_W-1:0] tag_ff, tag_in;

   // empty cells count as greater so new records land behind stored ones
   assign gt = !valid_ff || (key_ff > new_key);

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      tag_in   = tag_ff;
      if (ctl.drain) begin
         valid_in = next_rec.valid;
         key_in   = next_rec.key;
         tag_in   = next_rec.tag;
      end else if (ctl.insert && gt) begin
         if (prev_gt) begin
            valid_in = prev_rec.valid;
            key_in   = prev_rec.key;
            tag_in   = prev_rec.tag;
         end else begin
            valid_in = 1'b1;
            key_in   = new_key;
            tag_in   = new_tag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

   assign rec.valid = valid_ff;
   assign rec.key   = key_ff;
   assign rec.tag   = tag_ff;

endmodule

FILE: rtl/stable_ascending_key_sorter.sv
// top level of the stable ascending key sorter
//
// records come in on req while start is high and busy is low, one transfer
// per cycle. each record is placed into a chain of CAPACITY cells that keeps
// the stored records in ascending key order at all times; a record with a key
// equal to stored ones lands behind them, so load order is kept.
// a record that arrives while all cells are full is dropped and the set is
// flagged in dropped_records.
// after the transfer that carries final_record, busy is high while the
// chain shifts its stored records toward cell zero; the results pass from
// cell zero through the output registers and appear on rsp with rsp_strobe
// for one cycle each, in consecutive cycles. end_of_run marks the last.
// the receiver cannot stall: every strobed result must be taken.
// reset empties the chain, clears the drop flag and ends any drain.
module stable_ascending_key_sorter import sks_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  sks_req_type req,
   output logic        rsp_strobe,
   output sks_rsp_type rsp
);

   sks_rec_type           rec [CAPACITY];
   logic [CAPACITY-1:0]   gt;
   logic [CAPACITY-1:0]   valid_vec;
   sks_ctl_type           ctl;

   logic        emit_ff, emit_in;
   logic        overflow_ff, overflow_in;
   logic        strobe_ff, strobe_in;
   sks_rsp_type rsp_ff, rsp_in;

   logic accept;
   logic full;
   logic last_out;

   assign accept     = start && !emit_ff;
   assign full       = rec[CAPACITY-1].valid;
   assign ctl.insert = accept && !full;
   assign ctl.drain  = emit_ff;
   assign last_out   = !rec[1].valid;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      sks_rec_type prev_rec;
      logic        prev_gt;
      sks_rec_type next_rec;

      if (i == 0) begin : g_head
         assign prev_rec = '0;
         assign prev_gt  = 1'b0;
      end else begin : g_body
         assign prev_rec = rec[i-1];
         assign prev_gt  = gt[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_rec = '0;
      end else begin : g_inner
         assign next_rec = rec[i+1];
      end

      sks_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .new_key  (req.sort_key),
         .new_tag  (req.payload_tag),
         .prev_rec (prev_rec),
         .prev_gt  (prev_gt),
         .next_rec (next_rec),
         .rec      (rec[i]),
         .gt       (gt[i])
      );

      assign valid_vec[i] = rec[i].valid;
   end

   always_comb begin
      emit_in     = emit_ff;
      overflow_in = overflow_ff;
      if (accept) begin
         if (full) begin
            overflow_in = 1'b1;
         end
         if (req.final_record) begin
            emit_in = 1'b1;
         end
      end
      if (emit_ff && last_out) begin
         emit_in     = 1'b0;
         overflow_in = 1'b0;
      end
      strobe_in              = emit_ff;
      rsp_in.sorted_key      = rec[0].key;
      rsp_in.sorted_tag      = rec[0].tag;
      rsp_in.end_of_run      = last_out;
      rsp_in.dropped_records = overflow_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_ff     <= 1'b0;
         overflow_ff <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         emit_ff     <= emit_in;
         overflow_ff <= overflow_in;
         strobe_ff   <= strobe_in;
      end
      rsp_ff <= rsp_in;
   end

   assign busy       = emit_ff;
   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

   // stored records always fill the chain from the head without gaps
   a_packed: assert property (@(posedge clock) disable iff (reset)
      (valid_vec & (valid_vec + 1'b1)) == '0)
      else $error("gap in sorting chain");

   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      emit_ff |-> rec[0].valid)
      else $error("drain from empty chain");

   a_strobe_after_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(emit_ff))
      else $error("result transfer without drain");

   a_end_closes_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp.end_of_run) |-> (!emit_ff && !overflow_ff))
      else $error("drain still open after last result");

   a_ascending: assert property (@(posedge clock) disable iff (reset)
      (emit_ff && rec[1].valid) |-> (rec[0].key <= rec[1].key))
      else $error("chain head out of order");

endmodule
